### hdl/fbfa_pkg.sv
// Shared types, constants and helper functions for the fixed block free-list allocator.
package fbfa_pkg;

  localparam int MAX_BLOCKS    = 1024;
  localparam int POINTER_BYTES = 4;

  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 16;
  localparam int ALIGN_W   = 13;
  localparam int OFS_W     = 12;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;

  localparam int IDX_W    = $clog2(MAX_BLOCKS);
  localparam int SLOT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int MASK_W   = ALIGN_W - 1;
  localparam int FIRST_W  = ADDR_W + 2;
  localparam int STRIDE_W = LEN_W + 1;
  localparam int DIFF_W   = FIRST_W + 1;
  localparam int PROD_W   = SLOT_W + STRIDE_W;
  localparam int STEP_W   = $clog2(ADDR_W);

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REGION_BEGIN = 3'd0,
    REG_REGION_END   = 3'd1,
    REG_BLK_SIZE     = 3'd2,
    REG_ALIGNMENT    = 3'd3,
    REG_BLOCK_OFFSET = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEOM,
    ST_PREP,
    ST_DIVIDE,
    ST_EVAL,
    ST_LINK,
    ST_ALLOC,
    ST_DONE
  } state_t;

  // The largest power of two not above the alignment, less one; zero acts as one.
  function automatic logic [MASK_W-1:0] align_mask(input logic [ALIGN_W-1:0] alignment);
    logic [ALIGN_W-1:0] pow;
    pow = ALIGN_W'(1);
    for (int i = 0; i < ALIGN_W; i++) begin
      if (alignment[i]) begin
        pow = ALIGN_W'(1) << i;
      end
    end
    return MASK_W'(pow - ALIGN_W'(1));
  endfunction

endpackage

### hdl/fbfa_req_if.sv
// Request channel carrying the operation code and the block address.
interface fbfa_req_if;
  logic                        valid;
  logic                        ready;
  logic [fbfa_pkg::OP_W-1:0]   op;
  logic [fbfa_pkg::ADDR_W-1:0] block_address;

  modport source (output valid, output op, output block_address, input ready);
  modport sink (input valid, input op, input block_address, output ready);
endinterface

### hdl/fbfa_rsp_if.sv
// Response channel carrying the result address and the status.
interface fbfa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [fbfa_pkg::ADDR_W-1:0] result_address;
  logic [fbfa_pkg::STAT_W-1:0] status;

  modport source (output valid, output result_address, output status, input ready);
  modport sink (input valid, input result_address, input status, output ready);
endinterface

### hdl/fbfa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fbfa_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/fixed_block_free_list_allocator_top.sv
// Fixed block free-list allocator: geometry, shared divider, link walk and LIFO list.
// Allocate reads the head link and forms its address; an empty list goes straight to the result.
// Free runs the prep check, the 32-step shared divider and the evaluation; init adds the geometry
// first and the link walk last. A misfit ends at the prep check; one item is in work at a time.
// The result register lets a new request in while the previous result waits for its transfer.
// Synchronous reset clears the list to empty, the geometry to zero and the registers to defaults.
module fixed_block_free_list_allocator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fbfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbfa_pkg::CFG_W-1:0]     cfg_data,
  fbfa_req_if.sink                       req,
  fbfa_rsp_if.source                     rsp
);
  import fbfa_pkg::*;

  logic [ADDR_W-1:0]  region_begin;
  logic [ADDR_W-1:0]  region_end;
  logic [LEN_W-1:0]   blk_size;
  logic [ALIGN_W-1:0] alignment;
  logic [OFS_W-1:0]   block_offset;

  state_t state, state_next;
  logic [OP_W-1:0]     op_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [FIRST_W-1:0]  first_address, first_address_next;
  logic [STRIDE_W-1:0] slot_stride, slot_stride_next;
  logic [SLOT_W-1:0]   slot_count, slot_count_next;
  logic [SLOT_W-1:0]   head_slot, head_slot_next;
  logic [STRIDE_W-1:0] rem, rem_next;
  logic [ADDR_W-1:0]   dq, dq_next;
  logic [STEP_W-1:0]   step, step_next;
  logic [SLOT_W-1:0]   walk, walk_next;
  logic [ADDR_W-1:0]   res, res_next;
  status_t             stat, stat_next;
  logic                out_valid;
  logic [ADDR_W-1:0]   out_addr;
  logic [STAT_W-1:0]   out_stat;
  logic                out_load;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [SLOT_W-1:0]   ram_wdata;
  logic [SLOT_W-1:0]   ram_rdata;

  logic [LEN_W-1:0]    len_eff;
  logic [MASK_W-1:0]   amask;
  logic [FIRST_W-1:0]  first_sum;
  logic [STRIDE_W-1:0] stride_sum;
  logic [ADDR_W-1:0]   sub_opnd;
  logic [LEN_W-1:0]    sub_len;
  logic [DIFF_W-1:0]   diff;
  logic                fits;
  logic [STRIDE_W:0]   partial;
  logic                ge;
  logic [STRIDE_W:0]   partial_sub;
  logic [SLOT_W-1:0]   walk_inc;
  logic [SLOT_W-1:0]   link_val;
  logic [SLOT_W-1:0]   count_clamped;
  logic [PROD_W-1:0]   prod;
  logic [ADDR_W-1:0]   alloc_addr;
  logic                idle_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_begin <= '0;
      region_end   <= '0;
      blk_size     <= LEN_W'(4);
      alignment    <= ALIGN_W'(4);
      block_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REGION_BEGIN: region_begin <= cfg_data[ADDR_W-1:0];
        REG_REGION_END:   region_end   <= cfg_data[ADDR_W-1:0];
        REG_BLK_SIZE:     blk_size     <= cfg_data[LEN_W-1:0];
        REG_ALIGNMENT:    alignment    <= cfg_data[ALIGN_W-1:0];
        REG_BLOCK_OFFSET: block_offset <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_eff    = (blk_size < LEN_W'(POINTER_BYTES)) ? LEN_W'(POINTER_BYTES) : blk_size;
    amask      = align_mask(alignment);
    first_sum  = FIRST_W'(region_begin) + FIRST_W'(block_offset) + FIRST_W'(amask);
    stride_sum = STRIDE_W'(block_offset) + STRIDE_W'(len_eff) + STRIDE_W'(amask);
  end

  always_comb begin
    sub_opnd = (op_q == OP_INIT) ? region_end : addr_q;
    sub_len  = (op_q == OP_INIT) ? len_eff : '0;
    diff     = DIFF_W'(sub_opnd) - DIFF_W'(first_address) - DIFF_W'(sub_len);
    fits     = !diff[DIFF_W-1];
  end

  always_comb begin
    partial     = {rem, dq[ADDR_W-1]};
    ge          = partial >= {1'b0, slot_stride};
    partial_sub = partial - {1'b0, slot_stride};
  end

  always_comb begin
    walk_inc      = walk + SLOT_W'(1);
    link_val      = (walk_inc < slot_count) ? walk_inc : SLOT_W'(MAX_BLOCKS);
    count_clamped = (dq >= ADDR_W'(MAX_BLOCKS - 1)) ? SLOT_W'(MAX_BLOCKS)
                                                    : SLOT_W'(dq) + SLOT_W'(1);
    prod          = PROD_W'(head_slot) * PROD_W'(slot_stride);
    alloc_addr    = first_address[ADDR_W-1:0] + ADDR_W'(prod);
  end

  assign idle_take = (state == ST_IDLE) && req.valid;
  assign out_load  = (state == ST_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          case (req.op)
            OP_INIT:  state_next = ST_GEOM;
            OP_ALLOC: state_next = (head_slot < slot_count) ? ST_ALLOC : ST_DONE;
            OP_FREE:  state_next = ST_PREP;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_GEOM: state_next = ST_PREP;
      ST_PREP: begin
        if (fits && (op_q == OP_INIT || slot_count != '0)) begin
          state_next = ST_DIVIDE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIVIDE: begin
        if (step == STEP_W'(ADDR_W - 1)) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL:  state_next = (op_q == OP_INIT) ? ST_LINK : ST_DONE;
      ST_LINK: begin
        if (walk_inc == slot_count) begin
          state_next = ST_DONE;
        end
      end
      ST_ALLOC: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    first_address_next = first_address;
    slot_stride_next   = slot_stride;
    slot_count_next    = slot_count;
    head_slot_next     = head_slot;
    rem_next           = rem;
    dq_next            = dq;
    step_next          = step;
    walk_next          = walk;
    res_next           = res;
    stat_next          = stat;
    ram_we             = 1'b0;
    ram_waddr          = walk[IDX_W-1:0];
    ram_wdata          = link_val;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          res_next  = '0;
          stat_next = (req.op == OP_ALLOC && !(head_slot < slot_count)) ? STAT_EMPTY : STAT_OK;
        end
      end
      ST_GEOM: begin
        first_address_next = first_sum & ~FIRST_W'(amask);
        slot_stride_next   = stride_sum & ~STRIDE_W'(amask);
      end
      ST_PREP: begin
        rem_next  = '0;
        dq_next   = diff[ADDR_W-1:0];
        step_next = '0;
        if (op_q == OP_INIT) begin
          if (!fits) begin
            slot_count_next = '0;
            head_slot_next  = SLOT_W'(MAX_BLOCKS);
            stat_next       = STAT_EMPTY;
          end
        end else if (!fits || slot_count == '0) begin
          stat_next = STAT_RANGE;
        end
      end
      ST_DIVIDE: begin
        rem_next  = ge ? partial_sub[STRIDE_W-1:0] : partial[STRIDE_W-1:0];
        dq_next   = {dq[ADDR_W-2:0], ge};
        step_next = step + STEP_W'(1);
      end
      ST_EVAL: begin
        if (op_q == OP_INIT) begin
          slot_count_next = count_clamped;
          head_slot_next  = '0;
          res_next        = first_address[ADDR_W-1:0];
          walk_next       = '0;
        end else if (dq < ADDR_W'(slot_count)) begin
          ram_we         = 1'b1;
          ram_waddr      = dq[IDX_W-1:0];
          ram_wdata      = head_slot;
          head_slot_next = SLOT_W'(dq);
        end else begin
          stat_next = STAT_RANGE;
        end
      end
      ST_LINK: begin
        ram_we    = 1'b1;
        walk_next = walk_inc;
      end
      ST_ALLOC: begin
        res_next       = alloc_addr;
        head_slot_next = ram_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      first_address <= '0;
      slot_stride   <= '0;
      slot_count    <= '0;
      head_slot     <= SLOT_W'(MAX_BLOCKS);
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      first_address <= first_address_next;
      slot_stride   <= slot_stride_next;
      slot_count    <= slot_count_next;
      head_slot     <= head_slot_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (idle_take) begin
      op_q   <= req.op;
      addr_q <= req.block_address;
    end
    rem  <= rem_next;
    dq   <= dq_next;
    step <= step_next;
    walk <= walk_next;
    res  <= res_next;
    stat <= stat_next;
    if (out_load) begin
      out_addr <= res;
      out_stat <= stat;
    end
  end

  fbfa_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(MAX_BLOCKS)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(head_slot[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  assign req.ready          = (state == ST_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.result_address = out_addr;
  assign rsp.status         = out_stat;

endmodule

### hdl/fbfa_checker.sv
// Port-level checker for the allocator and the bind that attaches it to the top level.
module fbfa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [fbfa_pkg::ADDR_W-1:0]    rsp_result_address,
  input logic [fbfa_pkg::STAT_W-1:0]    rsp_status
);
  import fbfa_pkg::*;

  // A pending result stays offered until its transfer.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped before its transfer");

  // Only one request is in work: the channel closes after every request transfer.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in work");

  // A failed request never reports an address.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != STAT_OK |-> rsp_result_address == '0)
    else $error("non-zero address with a failure status");

  // The status carries one of the three defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status == STAT_OK || rsp_status == STAT_EMPTY
                  || rsp_status == STAT_RANGE)
    else $error("undefined status code");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid straight after reset");

endmodule

bind fixed_block_free_list_allocator_top fbfa_checker u_fbfa_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_result_address(rsp.result_address),
  .rsp_status        (rsp.status)
);

### test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the fixed block free-list allocator: directed table, then random phases.
module tb_top;
  import fbfa_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int TOTAL_ITEMS    = 1900;
  localparam int QUIET_FROM     = 1700;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 40;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } outcome_t;

  typedef struct {
    logic              is_write;
    cfg_reg_t          sel;
    logic [CFG_W-1:0]  data;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic              typed;
    outcome_t          want;
  } script_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  fbfa_req_if req_ch ();
  fbfa_rsp_if rsp_ch ();

  fixed_block_free_list_allocator_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Mirror of the pool: register copies, latched geometry and the LIFO list.
  logic [CFG_W-1:0]  reg_copy [5];
  logic [SLOT_W-1:0] shadow_link [MAX_BLOCKS];
  logic [SLOT_W-1:0] shadow_head;
  logic [SLOT_W-1:0] shadow_count;
  logic [63:0]       shadow_first;
  logic [63:0]       shadow_stride;

  outcome_t          pool_outcomes [$];
  logic [ADDR_W-1:0] handed_out [$];
  script_row_t       script [$];
  int                items_sent;
  int                fail_count;
  int                quiet_cycles;
  bit                idle_on;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void work_out_geometry(output logic [63:0] first,
                                            output logic [63:0] stride,
                                            output logic [63:0] len);
    logic [63:0] grain;
    grain = 64'd1;
    while ((grain << 1) <= 64'(reg_copy[int'(REG_ALIGNMENT)]) && grain < 64'd4096) begin
      grain = grain << 1;
    end
    len = 64'(reg_copy[int'(REG_BLK_SIZE)]);
    if (len < POINTER_BYTES) begin
      len = POINTER_BYTES;
    end
    first = (64'(reg_copy[int'(REG_REGION_BEGIN)]) + 64'(reg_copy[int'(REG_BLOCK_OFFSET)])
             + grain - 64'd1) & ~(grain - 64'd1);
    stride = (64'(reg_copy[int'(REG_BLOCK_OFFSET)]) + len + grain - 64'd1) & ~(grain - 64'd1);
  endfunction

  task automatic step_pool(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                           output outcome_t got);
    logic [63:0] first;
    logic [63:0] stride;
    logic [63:0] len;
    logic [63:0] stop;
    logic [63:0] n;
    logic [63:0] idx;
    got.addr = '0;
    got.status = STAT_OK;
    case (op)
      OP_INIT: begin
        work_out_geometry(first, stride, len);
        stop = 64'(reg_copy[int'(REG_REGION_END)]);
        n = 64'd0;
        if (stop >= first && stop - first >= len) begin
          n = (stop - first - len) / stride + 64'd1;
        end
        if (n > MAX_BLOCKS) begin
          n = MAX_BLOCKS;
        end
        shadow_first = first;
        shadow_stride = stride;
        shadow_count = SLOT_W'(n);
        for (int k = 0; k < MAX_BLOCKS; k++) begin
          if (k < n) begin
            shadow_link[k] = (k + 1 < n) ? SLOT_W'(k + 1) : SLOT_W'(MAX_BLOCKS);
          end
        end
        if (n > 0) begin
          shadow_head = '0;
          got.addr = first[ADDR_W-1:0];
        end else begin
          shadow_head = SLOT_W'(MAX_BLOCKS);
          got.status = STAT_EMPTY;
        end
      end
      OP_ALLOC: begin
        if (shadow_head < shadow_count) begin
          got.addr = ADDR_W'(shadow_first + 64'(shadow_head) * shadow_stride);
          shadow_head = shadow_link[shadow_head[IDX_W-1:0]];
        end else begin
          got.status = STAT_EMPTY;
        end
      end
      OP_FREE: begin
        if (shadow_count == 0 || 64'(addr) < shadow_first) begin
          got.status = STAT_RANGE;
        end else begin
          idx = (64'(addr) - shadow_first) / shadow_stride;
          if (idx >= 64'(shadow_count)) begin
            got.status = STAT_RANGE;
          end else begin
            shadow_link[idx[IDX_W-1:0]] = shadow_head;
            shadow_head = SLOT_W'(idx);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= data;
    case (sel)
      REG_BLK_SIZE:     reg_copy[int'(sel)] = CFG_W'(data[LEN_W-1:0]);
      REG_ALIGNMENT:    reg_copy[int'(sel)] = CFG_W'(data[ALIGN_W-1:0]);
      REG_BLOCK_OFFSET: reg_copy[int'(sel)] = CFG_W'(data[OFS_W-1:0]);
      default:          reg_copy[int'(sel)] = data;
    endcase
    @(negedge clk);
  endtask

  task automatic push_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                              input logic typed, input outcome_t want);
    outcome_t got;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.block_address <= addr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    step_pool(op, addr, got);
    pool_outcomes.push_back(typed ? want : got);
    if (op == OP_INIT) begin
      handed_out.delete();
    end else if (op == OP_ALLOC && got.status == STAT_OK) begin
      handed_out.push_back(got.addr);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pool_outcomes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void add_write(input cfg_reg_t sel, input logic [CFG_W-1:0] data);
    script_row_t row;
    row.is_write = 1'b1;
    row.sel = sel;
    row.data = data;
    row.op = OP_INIT;
    row.addr = '0;
    row.typed = 1'b0;
    row.want.addr = '0;
    row.want.status = STAT_OK;
    script.push_back(row);
  endfunction

  function automatic void add_check(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                    input logic typed, input logic [ADDR_W-1:0] want_addr,
                                    input status_t want_status);
    script_row_t row;
    row.is_write = 1'b0;
    row.sel = REG_REGION_BEGIN;
    row.data = '0;
    row.op = op;
    row.addr = addr;
    row.typed = typed;
    row.want.addr = want_addr;
    row.want.status = want_status;
    script.push_back(row);
  endfunction

  function automatic void build_script();
    add_check(OP_ALLOC, 32'h0000_0000, 1'b1, 32'h0, STAT_EMPTY);
    add_check(OP_FREE,  32'h0000_0000, 1'b1, 32'h0, STAT_RANGE);
    add_check(OP_SPARE, 32'hFFFF_FFFF, 1'b1, 32'h0, STAT_OK);
    add_check(OP_INIT,  32'h0000_0000, 1'b1, 32'h0, STAT_EMPTY);
    add_write(REG_REGION_BEGIN, 32'h0000_1000);
    add_write(REG_REGION_END,   32'h0000_1040);
    add_write(REG_BLK_SIZE,     32'd16);
    add_write(REG_ALIGNMENT,    32'd4);
    add_write(REG_BLOCK_OFFSET, 32'd0);
    add_check(OP_ALLOC, 32'h0000_0000, 1'b1, 32'h0, STAT_EMPTY);
    add_check(OP_INIT,  32'h0000_0000, 1'b1, 32'h0000_1000, STAT_OK);
    add_check(OP_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_1000, STAT_OK);
    add_check(OP_ALLOC, 32'h0000_0000, 1'b0, 32'h0, STAT_OK);
    add_check(OP_ALLOC, 32'h0000_0000, 1'b0, 32'h0, STAT_OK);
    add_check(OP_ALLOC, 32'h0000_0000, 1'b0, 32'h0, STAT_OK);
    add_check(OP_ALLOC, 32'h0000_0000, 1'b1, 32'h0, STAT_EMPTY);
    add_check(OP_FREE,  32'h0000_1005, 1'b1, 32'h0, STAT_OK);
    add_check(OP_FREE,  32'h0000_0FFF, 1'b1, 32'h0, STAT_RANGE);
    add_check(OP_FREE,  32'h0000_1040, 1'b1, 32'h0, STAT_RANGE);
    add_check(OP_FREE,  32'h0000_1010, 1'b0, 32'h0, STAT_OK);
    add_check(OP_FREE,  32'h0000_1010, 1'b0, 32'h0, STAT_OK);
    add_check(OP_ALLOC, 32'h0000_0000, 1'b0, 32'h0, STAT_OK);
    add_check(OP_ALLOC, 32'h0000_0000, 1'b0, 32'h0, STAT_OK);
    add_check(OP_ALLOC, 32'h0000_0000, 1'b0, 32'h0, STAT_OK);
    add_write(REG_REGION_BEGIN, 32'hFFFF_FFF0);
    add_write(REG_REGION_END,   32'hFFFF_FFFF);
    add_write(REG_BLK_SIZE,     32'd1);
    add_write(REG_ALIGNMENT,    32'd0);
    add_write(REG_BLOCK_OFFSET, 32'd4095);
    add_check(OP_INIT,  32'h0000_0000, 1'b1, 32'h0, STAT_EMPTY);
    add_write(REG_REGION_BEGIN, 32'h0000_0000);
    add_write(REG_BLK_SIZE,     32'd65535);
    add_write(REG_ALIGNMENT,    32'd8191);
    add_check(OP_INIT,  32'h0000_0000, 1'b1, 32'h0000_1000, STAT_OK);
    add_check(OP_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_1000, STAT_OK);
    add_check(OP_FREE,  32'hFFFF_FFFF, 1'b1, 32'h0, STAT_RANGE);
    add_check(OP_FREE,  32'h043F_0005, 1'b0, 32'h0, STAT_OK);
    add_check(OP_ALLOC, 32'h0000_0000, 1'b0, 32'h0, STAT_OK);
  endfunction

  task automatic plan_pool();
    logic [CFG_W-1:0] base_val;
    logic [CFG_W-1:0] len_val;
    logic [CFG_W-1:0] grain_val;
    logic [CFG_W-1:0] pad_val;
    logic [63:0]      first;
    logic [63:0]      stride;
    logic [63:0]      len;
    logic [63:0]      stop;
    int               target;
    base_val = ($urandom_range(0, 7) == 0) ? (32'hFFFF_0000 | $urandom_range(0, 65535)) : $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: len_val = $urandom_range(1, 64);
      5, 6, 7:       len_val = $urandom_range(1, 4096);
      8:             len_val = $urandom_range(0, 65535);
      default:       len_val = $urandom_range(0, 1) ? 32'd65535 : $urandom_range(0, 4);
    endcase
    grain_val = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
                                            : (32'd1 << $urandom_range(0, 12));
    case ($urandom_range(0, 2))
      0:       pad_val = 32'd0;
      1:       pad_val = $urandom_range(0, 16);
      default: pad_val = $urandom_range(0, 4095);
    endcase
    if ($urandom_range(0, 5) == 0) begin
      len_val = len_val | ($urandom << LEN_W);
      grain_val = grain_val | ($urandom << ALIGN_W);
      pad_val = pad_val | ($urandom << OFS_W);
    end
    write_reg(REG_REGION_BEGIN, base_val);
    write_reg(REG_BLK_SIZE, len_val);
    write_reg(REG_ALIGNMENT, grain_val);
    write_reg(REG_BLOCK_OFFSET, pad_val);
    work_out_geometry(first, stride, len);
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 1100) : $urandom_range(0, 40);
    if ($urandom_range(0, 7) == 0) begin
      stop = 64'($urandom);
    end else if (target == 0) begin
      stop = first + 64'($urandom_range(0, 32'(len) - 1));
    end else begin
      stop = first + len + 64'(target - 1) * stride + 64'($urandom_range(0, 32'(stride) - 1));
    end
    if (stop > 64'hFFFF_FFFF) begin
      stop = 64'hFFFF_FFFF;
    end
    write_reg(REG_REGION_END, stop[CFG_W-1:0]);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_release(output logic [ADDR_W-1:0] addr);
    int    roll;
    int    j;
    longint k;
    roll = $urandom_range(0, 99);
    if (handed_out.size() != 0 && roll < 60) begin
      j = $urandom_range(0, handed_out.size() - 1);
      addr = handed_out[j];
      handed_out.delete(j);
    end else if (handed_out.size() != 0 && roll < 65) begin
      addr = handed_out[$urandom_range(0, handed_out.size() - 1)];
    end else if (shadow_count != 0 && roll < 85) begin
      k = $urandom_range(0, 32'(shadow_count));
      addr = ADDR_W'(shadow_first + 64'(k) * shadow_stride);
      if ($urandom_range(0, 2) == 0) begin
        addr = addr + $urandom_range(0, 32'(shadow_stride) - 1);
      end
    end else if (shadow_first != 0 && roll < 92) begin
      addr = ADDR_W'(shadow_first - 64'($urandom_range(1, 64)));
    end else begin
      addr = $urandom;
    end
  endtask

  initial begin : rsp_stall
    int gap;
    gap = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        gap--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        gap = $urandom_range(1, 8) - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pool_outcomes.size() == 0) begin
        $error("result transfer with nothing outstanding: result_address %h, status %0d",
               rsp_ch.result_address, rsp_ch.status);
        fail_count++;
      end else begin
        want = pool_outcomes.pop_front();
        if (rsp_ch.result_address !== want.addr) begin
          $error("result_address: expected %h, actual %h", want.addr, rsp_ch.result_address);
          fail_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
          fail_count++;
        end
      end
    end
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic              in_write;
    logic [ADDR_W-1:0] addr;
    int                phase_len;
    int                roll;
    outcome_t          none;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_REGION_BEGIN;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_INIT;
    req_ch.block_address = '0;
    none.addr = '0;
    none.status = STAT_OK;
    in_write = 1'b0;
    items_sent = 0;
    fail_count = 0;
    quiet_cycles = 0;
    idle_on = 1'b1;
    reg_copy[int'(REG_REGION_BEGIN)] = 32'd0;
    reg_copy[int'(REG_REGION_END)] = 32'd0;
    reg_copy[int'(REG_BLK_SIZE)] = 32'd4;
    reg_copy[int'(REG_ALIGNMENT)] = 32'd4;
    reg_copy[int'(REG_BLOCK_OFFSET)] = 32'd0;
    shadow_head = SLOT_W'(MAX_BLOCKS);
    shadow_count = '0;
    shadow_first = '0;
    shadow_stride = '0;
    build_script();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_write) begin
        if (!in_write) begin
          drain_results();
        end
        write_reg(script[i].sel, script[i].data);
        in_write = 1'b1;
      end else begin
        if (in_write) begin
          cfg_we <= 1'b0;
          in_write = 1'b0;
        end
        push_request(script[i].op, script[i].addr, script[i].typed, script[i].want);
      end
    end

    while (items_sent < TOTAL_ITEMS) begin
      drain_results();
      plan_pool();
      idle_on = (items_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(20, 80);
      if ($urandom_range(0, 4) != 0) begin
        push_request(OP_INIT, $urandom, 1'b0, none);
      end
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 44) begin
          push_request(OP_ALLOC, $urandom, 1'b0, none);
        end else if (roll < 90) begin
          pick_release(addr);
          push_request(OP_FREE, addr, 1'b0, none);
        end else if (roll < 96) begin
          push_request(OP_INIT, $urandom, 1'b0, none);
        end else begin
          push_request(OP_SPARE, $urandom, 1'b0, none);
        end
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pool_outcomes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
